// ===== src/assert_macros.svh =====
//------------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implications with a synchronous reset that disables
// the check.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FMPT_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define FMPT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/fmpt_pkg.sv =====
//------------------------------------------------------------------------------
// fmpt_pkg
// Types, codes and fixed widths shared by the frame mailbox modules.
//------------------------------------------------------------------------------
`default_nettype none

package fmpt_pkg;

   localparam int HANDLE_W    = 64;
   localparam int DIM_W       = 14;
   localparam int FPS_W       = 10;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int TS_W        = 60;
   localparam int DUR_W       = 24;
   localparam int CNT_W       = 32;
   localparam int NUM_CNT     = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_SUBMIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DELIVERED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNDERRUN   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RESET_DONE = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FPS    = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd1080;
   localparam logic [FPS_W-1:0] FPS_RESET    = 10'd30;

   localparam int CNT_SUBMITTED   = 0;
   localparam int CNT_REJECTED    = 1;
   localparam int CNT_OVERWRITTEN = 2;
   localparam int CNT_REPEAT      = 3;
   localparam int CNT_UNDERRUN    = 4;
   localparam int CNT_DELIVERED   = 5;

   typedef enum logic [1:0] {
      OP_SUBMIT_OK,
      OP_SUBMIT_BAD,
      OP_REQUEST,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } frame_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_SUM,
      ST_STAMP_START,
      ST_STAMP_WAIT,
      ST_DUR_START,
      ST_DUR_WAIT,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/frame_mailbox_paced_timestamps.sv =====
//------------------------------------------------------------------------------
// frame_mailbox_paced_timestamps
// One-slot latest-frame mailbox that stamps each delivered sample with a
// paced presentation time and duration.
//
// Items on the req_ channel submit a frame, request a sample or clear the
// mailbox, the sample index and the counters; an item with the unused
// command code is taken and dropped. Others give one rsp_ item each, in order.
// Registers are written through the csr_ channel, which is always ready; any
// write to a listed register also clears the mailbox and the counters.
// A submit, clear or underrun item goes from the queue head through ST_EMIT.
// A delivering request multiplies the sample index by TICKS_PER_SECOND and
// then divides twice on the shared divider, which retires two quotient bits
// per cycle, over INDEX_BITS + T and T + 1 bit operands, T being the bit
// width of TICKS_PER_SECOND, rounded up to even operand widths.
// A two-entry queue sits behind req_, so the next items are taken while the
// back end works or while a result waits on rsp_ready. When rsp_ready stays
// low the result is held, the back end stops and req_ready drops once the
// queue is full. Reset empties the queue, restores the register defaults
// and clears the mailbox, the sample index and the counters.
//------------------------------------------------------------------------------
`default_nettype none

module frame_mailbox_paced_timestamps #(
   parameter int TICKS_PER_SECOND = 10000000,
   parameter int INDEX_BITS       = 36
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fmpt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fmpt_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fmpt_pkg::CMD_W-1:0]          req_command,
   input  logic [fmpt_pkg::DIM_W-1:0]          req_frame_width,
   input  logic [fmpt_pkg::DIM_W-1:0]          req_frame_height,
   input  logic [fmpt_pkg::HANDLE_W-1:0]       req_frame_handle,
   input  logic                                req_owner_present,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fmpt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fmpt_pkg::HANDLE_W-1:0]       rsp_delivered_handle,
   output logic [fmpt_pkg::TS_W-1:0]           rsp_timestamp,
   output logic [fmpt_pkg::DUR_W-1:0]          rsp_duration,
   output logic                                rsp_repeated,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_submitted_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_rejected_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_overwritten_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_repeat_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_underrun_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_delivered_count
);
   import fmpt_pkg::*;

   frame_cfg_type frame_cfg;
   logic          queue_full;
   logic          push;
   entry_type     push_entry;
   logic          pop;
   logic          head_valid;
   entry_type     head_entry;

   fmpt_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_frame_width   (req_frame_width),
      .req_frame_height  (req_frame_height),
      .req_frame_handle  (req_frame_handle),
      .req_owner_present (req_owner_present),
      .frame_cfg         (frame_cfg),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   fmpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   fmpt_back #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .INDEX_BITS       (INDEX_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .frame_cfg             (frame_cfg),
      .head_valid            (head_valid),
      .head_entry            (head_entry),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_delivered_handle  (rsp_delivered_handle),
      .rsp_timestamp         (rsp_timestamp),
      .rsp_duration          (rsp_duration),
      .rsp_repeated          (rsp_repeated),
      .rsp_submitted_count   (rsp_submitted_count),
      .rsp_rejected_count    (rsp_rejected_count),
      .rsp_overwritten_count (rsp_overwritten_count),
      .rsp_repeat_count      (rsp_repeat_count),
      .rsp_underrun_count    (rsp_underrun_count),
      .rsp_delivered_count   (rsp_delivered_count)
   );

endmodule

`default_nettype wire

// ===== src/fmpt_front.sv =====
//------------------------------------------------------------------------------
// fmpt_front
// Accepts request-channel items and classifies them into queue operations.
//------------------------------------------------------------------------------
`default_nettype none

module fmpt_front (
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fmpt_pkg::CMD_W-1:0]      req_command,
   input  logic [fmpt_pkg::DIM_W-1:0]      req_frame_width,
   input  logic [fmpt_pkg::DIM_W-1:0]      req_frame_height,
   input  logic [fmpt_pkg::HANDLE_W-1:0]   req_frame_handle,
   input  logic                            req_owner_present,
   input  fmpt_pkg::frame_cfg_type         frame_cfg,
   input  logic                            queue_full,
   output logic                            push,
   output fmpt_pkg::entry_type             push_entry
);
   import fmpt_pkg::*;

   logic frame_ok;
   logic keep;

   always_comb begin
      frame_ok = (req_frame_width == frame_cfg.width) &&
                 (req_frame_height == frame_cfg.height) &&
                 (req_frame_handle != '0) && req_owner_present;
      push_entry.handle = req_frame_handle;
      push_entry.op     = OP_REQUEST;
      keep              = 1'b1;
      case (req_command)
         CMD_SUBMIT: begin
            push_entry.op = frame_ok ? OP_SUBMIT_OK : OP_SUBMIT_BAD;
         end
         CMD_REQUEST: begin
            push_entry.op = OP_REQUEST;
         end
         CMD_CLEAR: begin
            push_entry.op = OP_CLEAR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full && keep;

endmodule

`default_nettype wire

// ===== src/fmpt_queue.sv =====
//------------------------------------------------------------------------------
// fmpt_queue
// Short FIFO of classified operations between the front and the back.
//------------------------------------------------------------------------------
`default_nettype none

module fmpt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fmpt_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output fmpt_pkg::entry_type head_entry
);
   import fmpt_pkg::*;

   entry_type          entries_ff [QUEUE_DEPTH];
   entry_type          entries_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_entry;
         wr_ptr_in             = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== src/fmpt_divider.sv =====
//------------------------------------------------------------------------------
// fmpt_divider
// Restoring divider by the frame rate, two quotient bits per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module fmpt_divider #(
   parameter  int WORK_W = 60,
   localparam int PAIR_W = $clog2(WORK_W / 2 + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [WORK_W-1:0]             dividend,
   input  logic [fmpt_pkg::FPS_W-1:0]    divisor,
   input  logic [PAIR_W-1:0]             pairs,
   output logic                          done,
   output logic [WORK_W-1:0]             quotient,
   output logic [fmpt_pkg::FPS_W-1:0]    remainder
);
   import fmpt_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PAIR_W-1:0] left_ff, left_in;
   logic [WORK_W-1:0] work_ff, work_in;
   logic [FPS_W-1:0]  rem_ff, rem_in;
   logic [FPS_W-1:0]  dsr_ff, dsr_in;
   logic [FPS_W:0]    trial_a, trial_b;
   logic [FPS_W-1:0]  rem_a, rem_b;
   logic              bit_a, bit_b;

   always_comb begin
      trial_a = {rem_ff, work_ff[WORK_W-1]};
      bit_a   = (trial_a >= {1'b0, dsr_ff});
      rem_a   = bit_a ? FPS_W'(trial_a - {1'b0, dsr_ff}) : trial_a[FPS_W-1:0];
      trial_b = {rem_a, work_ff[WORK_W-2]};
      bit_b   = (trial_b >= {1'b0, dsr_ff});
      rem_b   = bit_b ? FPS_W'(trial_b - {1'b0, dsr_ff}) : trial_b[FPS_W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      left_in = left_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         left_in = pairs;
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[WORK_W-3:0], bit_a, bit_b};
         rem_in  = rem_b;
         left_in = left_ff - PAIR_W'(1);
         if (left_ff == PAIR_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/fmpt_back.sv =====
//------------------------------------------------------------------------------
// fmpt_back
// Mailbox state, counters, timestamp sequencer and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module fmpt_back #(
   parameter int TICKS_PER_SECOND = 10000000,
   parameter int INDEX_BITS       = 36
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fmpt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fmpt_pkg::CSR_DATA_W-1:0]     csr_data,
   output fmpt_pkg::frame_cfg_type             frame_cfg,
   input  logic                                head_valid,
   input  fmpt_pkg::entry_type                 head_entry,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fmpt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fmpt_pkg::HANDLE_W-1:0]       rsp_delivered_handle,
   output logic [fmpt_pkg::TS_W-1:0]           rsp_timestamp,
   output logic [fmpt_pkg::DUR_W-1:0]          rsp_duration,
   output logic                                rsp_repeated,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_submitted_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_rejected_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_overwritten_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_repeat_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_underrun_count,
   output logic [fmpt_pkg::CNT_W-1:0]          rsp_delivered_count
);
   import fmpt_pkg::*;

   localparam int TW         = $clog2(TICKS_PER_SECOND + 1);
   localparam int HALF_W     = (INDEX_BITS + 1) / 2;
   localparam int PROD_W     = HALF_W + TW;
   localparam int FULL_W     = INDEX_BITS + TW;
   localparam int WORK_W     = FULL_W + FULL_W % 2;
   localparam int DUR_DIV_W  = TW + 1;
   localparam int DUR_WORK_W = DUR_DIV_W + DUR_DIV_W % 2;
   localparam int PAIR_W     = $clog2(WORK_W / 2 + 1);
   localparam logic [TW-1:0]         TICKS     = TW'(TICKS_PER_SECOND);
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   back_state_type            state_ff, state_in;
   logic [DIM_W-1:0]          width_ff, width_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic [FPS_W-1:0]          fps_ff, fps_in;
   logic                      pending_valid_ff, pending_valid_in;
   logic [HANDLE_W-1:0]       pending_frame_ff, pending_frame_in;
   logic                      last_valid_ff, last_valid_in;
   logic [HANDLE_W-1:0]       last_frame_ff, last_frame_in;
   logic [INDEX_BITS-1:0]     sample_ff, sample_in;
   logic [CNT_W-1:0]          counters_ff [NUM_CNT];
   logic [CNT_W-1:0]          counters_in [NUM_CNT];
   logic [INDEX_BITS-1:0]     idx_ff, idx_in;
   logic [PROD_W-1:0]         pp_ff, pp_in;
   logic [WORK_W-1:0]         acc_ff, acc_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]       res_handle_ff, res_handle_in;
   logic [TS_W-1:0]           res_ts_ff, res_ts_in;
   logic [DUR_W-1:0]          res_dur_ff, res_dur_in;
   logic                      res_rep_ff, res_rep_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]       rsp_handle_ff, rsp_handle_in;
   logic [TS_W-1:0]           rsp_ts_ff, rsp_ts_in;
   logic [DUR_W-1:0]          rsp_dur_ff, rsp_dur_in;
   logic                      rsp_rep_ff, rsp_rep_in;
   logic [CNT_W-1:0]          rsp_counts_ff [NUM_CNT];
   logic [CNT_W-1:0]          rsp_counts_in [NUM_CNT];

   logic [NUM_CNT-1:0]        bump;
   logic                      clear_all;
   logic                      div_start;
   logic [WORK_W-1:0]         div_dividend;
   logic [FPS_W-1:0]          div_divisor;
   logic [PAIR_W-1:0]         div_pairs;
   logic                      div_done;
   logic [WORK_W-1:0]         div_quot;
   logic [FPS_W-1:0]          div_rem;
   logic [DUR_DIV_W-1:0]      dur_sum;
   logic [TS_W+WORK_W-1:0]    ts_wide;
   logic [DUR_W+WORK_W-1:0]   dur_wide;

   assign div_divisor = (fps_ff == '0) ? FPS_W'(1) : fps_ff;
   assign dur_sum     = DUR_DIV_W'(div_rem) + DUR_DIV_W'(TICKS);
   assign ts_wide     = (TS_W + WORK_W)'(div_quot);
   assign dur_wide    = (DUR_W + WORK_W)'(div_quot);

   fmpt_divider #(
      .WORK_W (WORK_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .pairs     (div_pairs),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      state_in         = state_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      fps_in           = fps_ff;
      pending_valid_in = pending_valid_ff;
      pending_frame_in = pending_frame_ff;
      last_valid_in    = last_valid_ff;
      last_frame_in    = last_frame_ff;
      sample_in        = sample_ff;
      idx_in           = idx_ff;
      pp_in            = pp_ff;
      acc_in           = acc_ff;
      res_status_in    = res_status_ff;
      res_handle_in    = res_handle_ff;
      res_ts_in        = res_ts_ff;
      res_dur_in       = res_dur_ff;
      res_rep_in       = res_rep_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_handle_in    = rsp_handle_ff;
      rsp_ts_in        = rsp_ts_ff;
      rsp_dur_in       = rsp_dur_ff;
      rsp_rep_in       = rsp_rep_ff;
      rsp_counts_in    = rsp_counts_ff;
      pop              = 1'b0;
      bump             = '0;
      clear_all        = 1'b0;
      div_start        = 1'b0;
      div_dividend     = acc_ff;
      div_pairs        = PAIR_W'(WORK_W / 2);

      if (csr_valid) begin
         case (csr_index)
            REG_WIDTH: begin
               width_in  = csr_data[DIM_W-1:0];
               clear_all = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = csr_data[DIM_W-1:0];
               clear_all = 1'b1;
            end
            REG_FPS: begin
               fps_in    = csr_data[FPS_W-1:0];
               clear_all = 1'b1;
            end
            default: begin
               clear_all = 1'b0;
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop           = 1'b1;
               res_handle_in = '0;
               res_ts_in     = '0;
               res_dur_in    = '0;
               res_rep_in    = 1'b0;
               state_in      = ST_EMIT;
               case (head_entry.op)
                  OP_SUBMIT_OK: begin
                     res_status_in         = STATUS_ACCEPTED;
                     bump[CNT_SUBMITTED]   = 1'b1;
                     bump[CNT_OVERWRITTEN] = pending_valid_ff;
                     pending_valid_in      = 1'b1;
                     pending_frame_in      = head_entry.handle;
                  end
                  OP_SUBMIT_BAD: begin
                     res_status_in      = STATUS_REJECTED;
                     bump[CNT_REJECTED] = 1'b1;
                  end
                  OP_REQUEST: begin
                     if (pending_valid_ff || last_valid_ff) begin
                        res_status_in       = STATUS_DELIVERED;
                        res_rep_in          = !pending_valid_ff;
                        res_handle_in       = pending_valid_ff ? pending_frame_ff
                                                               : last_frame_ff;
                        last_valid_in       = 1'b1;
                        last_frame_in       = res_handle_in;
                        pending_valid_in    = 1'b0;
                        bump[CNT_REPEAT]    = !pending_valid_ff;
                        bump[CNT_DELIVERED] = 1'b1;
                        idx_in              = sample_ff;
                        if (sample_ff != INDEX_MAX) begin
                           sample_in = sample_ff + INDEX_BITS'(1);
                        end
                        state_in = ST_MUL_LO;
                     end else begin
                        res_status_in      = STATUS_UNDERRUN;
                        bump[CNT_UNDERRUN] = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     res_status_in = STATUS_RESET_DONE;
                     clear_all     = 1'b1;
                  end
                  default: begin
                     res_status_in = STATUS_REJECTED;
                  end
               endcase
            end
         end
         ST_MUL_LO: begin
            pp_in    = PROD_W'(idx_ff[HALF_W-1:0]) * PROD_W'(TICKS);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = WORK_W'(pp_ff);
            pp_in    = PROD_W'(idx_ff[INDEX_BITS-1:HALF_W]) * PROD_W'(TICKS);
            state_in = ST_MUL_SUM;
         end
         ST_MUL_SUM: begin
            acc_in   = acc_ff + (WORK_W'(pp_ff) << HALF_W);
            state_in = ST_STAMP_START;
         end
         ST_STAMP_START: begin
            div_start = 1'b1;
            state_in  = ST_STAMP_WAIT;
         end
         ST_STAMP_WAIT: begin
            if (div_done) begin
               res_ts_in = ts_wide[TS_W-1:0];
               acc_in    = WORK_W'(dur_sum) << (WORK_W - DUR_WORK_W);
               state_in  = ST_DUR_START;
            end
         end
         ST_DUR_START: begin
            div_start = 1'b1;
            div_pairs = PAIR_W'(DUR_WORK_W / 2);
            state_in  = ST_DUR_WAIT;
         end
         ST_DUR_WAIT: begin
            if (div_done) begin
               res_dur_in = dur_wide[DUR_W-1:0];
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_ts_in     = res_ts_ff;
               rsp_dur_in    = res_dur_ff;
               rsp_rep_in    = res_rep_ff;
               rsp_counts_in = counters_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      for (int i = 0; i < NUM_CNT; i++) begin
         counters_in[i] = counters_ff[i];
         if (clear_all) begin
            counters_in[i] = '0;
         end else if (bump[i] && (counters_ff[i] != '1)) begin
            counters_in[i] = counters_ff[i] + CNT_W'(1);
         end
      end

      if (clear_all) begin
         pending_valid_in = 1'b0;
         last_valid_in    = 1'b0;
         sample_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         width_ff         <= WIDTH_RESET;
         height_ff        <= HEIGHT_RESET;
         fps_ff           <= FPS_RESET;
         pending_valid_ff <= 1'b0;
         last_valid_ff    <= 1'b0;
         sample_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < NUM_CNT; i++) begin
            counters_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         fps_ff           <= fps_in;
         pending_valid_ff <= pending_valid_in;
         last_valid_ff    <= last_valid_in;
         sample_ff        <= sample_in;
         rsp_valid_ff     <= rsp_valid_in;
         counters_ff      <= counters_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_frame_ff <= pending_frame_in;
      last_frame_ff    <= last_frame_in;
      idx_ff           <= idx_in;
      pp_ff            <= pp_in;
      acc_ff           <= acc_in;
      res_status_ff    <= res_status_in;
      res_handle_ff    <= res_handle_in;
      res_ts_ff        <= res_ts_in;
      res_dur_ff       <= res_dur_in;
      res_rep_ff       <= res_rep_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_handle_ff    <= rsp_handle_in;
      rsp_ts_ff        <= rsp_ts_in;
      rsp_dur_ff       <= rsp_dur_in;
      rsp_rep_ff       <= rsp_rep_in;
      rsp_counts_ff    <= rsp_counts_in;
   end

   assign csr_ready        = 1'b1;
   assign frame_cfg.width  = width_ff;
   assign frame_cfg.height = height_ff;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_delivered_handle  = rsp_handle_ff;
   assign rsp_timestamp         = rsp_ts_ff;
   assign rsp_duration          = rsp_dur_ff;
   assign rsp_repeated          = rsp_rep_ff;
   assign rsp_submitted_count   = rsp_counts_ff[CNT_SUBMITTED];
   assign rsp_rejected_count    = rsp_counts_ff[CNT_REJECTED];
   assign rsp_overwritten_count = rsp_counts_ff[CNT_OVERWRITTEN];
   assign rsp_repeat_count      = rsp_counts_ff[CNT_REPEAT];
   assign rsp_underrun_count    = rsp_counts_ff[CNT_UNDERRUN];
   assign rsp_delivered_count   = rsp_counts_ff[CNT_DELIVERED];

endmodule

`default_nettype wire

// ===== src/fmpt_checker.sv =====
//------------------------------------------------------------------------------
// fmpt_checker
// Port-level checks on the result channel of the frame mailbox.
//------------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fmpt_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [fmpt_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [fmpt_pkg::HANDLE_W-1:0]       rsp_delivered_handle,
   input  logic [fmpt_pkg::TS_W-1:0]           rsp_timestamp,
   input  logic [fmpt_pkg::DUR_W-1:0]          rsp_duration,
   input  logic                                rsp_repeated,
   input  logic [fmpt_pkg::CNT_W-1:0]          rsp_submitted_count,
   input  logic [fmpt_pkg::CNT_W-1:0]          rsp_rejected_count,
   input  logic [fmpt_pkg::CNT_W-1:0]          rsp_overwritten_count,
   input  logic [fmpt_pkg::CNT_W-1:0]          rsp_repeat_count,
   input  logic [fmpt_pkg::CNT_W-1:0]          rsp_underrun_count,
   input  logic [fmpt_pkg::CNT_W-1:0]          rsp_delivered_count
);
   import fmpt_pkg::*;

   logic stalled;
   logic no_sample;
   logic all_zero;

   assign stalled   = rsp_valid && !rsp_ready;
   assign no_sample = (rsp_delivered_handle == '0) && (rsp_timestamp == '0) &&
                      (rsp_duration == '0) && !rsp_repeated;
   assign all_zero  = (rsp_submitted_count == '0) && (rsp_rejected_count == '0) &&
                      (rsp_overwritten_count == '0) && (rsp_repeat_count == '0) &&
                      (rsp_underrun_count == '0) && (rsp_delivered_count == '0);

   `FMPT_ASSERT_NEXT(a_valid_holds, clock, reset, stalled, rsp_valid, "rsp_valid dropped")
   `FMPT_ASSERT_NEXT(a_payload_holds, clock, reset, stalled, $stable(rsp_status) && $stable(rsp_delivered_handle) && $stable(rsp_timestamp), "stalled item changed")
   `FMPT_ASSERT_NOW(a_no_sample, clock, reset, rsp_valid && (rsp_status != STATUS_DELIVERED), no_sample, "sample fields set without a delivery")
   `FMPT_ASSERT_NOW(a_handle_nonzero, clock, reset, rsp_valid && (rsp_status == STATUS_DELIVERED), rsp_delivered_handle != '0, "delivered a zero handle")
   `FMPT_ASSERT_NOW(a_clear_counts, clock, reset, rsp_valid && (rsp_status == STATUS_RESET_DONE), all_zero, "counters not cleared by reset command")

endmodule

bind frame_mailbox_paced_timestamps fmpt_checker u_checker (.*);

`default_nettype wire
